### design/lva_pkg.sv
`default_nettype none
package lva_pkg;

   localparam int unsigned FIFO_DEPTH = 2;
   localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] CSR_UP_X = 2'd0;
   localparam logic [1:0] CSR_UP_Y = 2'd1;
   localparam logic [1:0] CSR_UP_Z = 2'd2;

   localparam logic [31:0] UP_X_RESET = 32'h0000_0000;
   localparam logic [31:0] UP_Y_RESET = 32'h0001_0000;
   localparam logic [31:0] UP_Z_RESET = 32'h0000_0000;

   // eye point, direction target - eye, zero-direction flag
   typedef struct packed {
      logic [2:0][31:0] eye;
      logic [2:0][32:0] dir;
      logic             dzero;
   } job_type;

   // four rows of three entries, entry a in element 0
   typedef struct packed {
      logic [3:0][2:0][31:0] ent;
      logic                  degen;
   } mat_type;

endpackage
`default_nettype wire

### design/lva_fifo.sv
`default_nettype none
module lva_fifo
   import lva_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output logic         full,
   input  wire logic    pop,
   output logic         empty,
   output job_type      head
);

   job_type            mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### design/lva_front.sv
`default_nettype none
module lva_front
   import lva_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [191:0] req_tdata,
   output logic              push,
   output job_type           push_data,
   input  wire logic         full
);

   logic    vld_ff, vld_in;
   job_type job_ff, job_in;
   logic    accept;
   logic signed [32:0] eye_s [3];
   logic signed [32:0] tgt_s [3];

   assign req_tready = !vld_ff || !full;
   assign accept     = req_tvalid && req_tready;
   assign push       = vld_ff;
   assign push_data  = job_ff;

   always_comb begin
      job_in = job_ff;
      vld_in = vld_ff;
      for (int i = 0; i < 3; i++) begin
         eye_s[i] = 33'(signed'(req_tdata[32*i +: 32]));
         tgt_s[i] = 33'(signed'(req_tdata[96 + 32*i +: 32]));
      end
      if (vld_ff && !full) begin
         vld_in = 1'b0;
      end
      if (accept) begin
         vld_in = 1'b1;
         for (int i = 0; i < 3; i++) begin
            job_in.eye[i] = req_tdata[32*i +: 32];
            job_in.dir[i] = tgt_s[i] - eye_s[i];
         end
         job_in.dzero = (eye_s[0] == tgt_s[0]) && (eye_s[1] == tgt_s[1])
                        && (eye_s[2] == tgt_s[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

endmodule
`default_nettype wire

### design/lva_core.sv
`default_nettype none
module lva_core
   import lva_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        empty,
   input  wire job_type     head,
   output logic             pop,
   input  wire logic [31:0] up_x,
   input  wire logic [31:0] up_y,
   input  wire logic [31:0] up_z,
   output logic             mat_valid,
   input  wire logic        mat_ready,
   output mat_type          mat
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ABS   = 4'd1;
   localparam logic [3:0] S_SHIFT = 4'd2;
   localparam logic [3:0] S_MUL   = 4'd3;
   localparam logic [3:0] S_ACC   = 4'd4;
   localparam logic [3:0] S_SQRT  = 4'd5;
   localparam logic [3:0] S_DIVI  = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_NEND  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   localparam logic [1:0] PH_SQ = 2'd0;
   localparam logic [1:0] PH_C  = 2'd1;
   localparam logic [1:0] PH_Y  = 2'd2;
   localparam logic [1:0] PH_T  = 2'd3;

   logic [3:0]          state_ff, state_in;
   logic [1:0]          ph_ff, ph_in;
   logic                pass_ff, pass_in;
   logic [1:0]          k_ff, k_in;
   logic [1:0]          j_ff, j_in;
   logic [4:0]          it_ff, it_in;
   logic signed [31:0]  eye_ff [3], eye_in [3];
   logic signed [49:0]  nv_ff [3], nv_in [3];
   logic [48:0]         mag_ff [3], mag_in [3];
   logic                neg_ff [3], neg_in [3];
   logic signed [65:0]  acc_ff, acc_in;
   logic signed [65:0]  prod_ff, prod_in;
   logic [63:0]         sn_ff, sn_in;
   logic [63:0]         sr_ff, sr_in;
   logic [31:0]         len_ff, len_in;
   logic [16:0]         nlo_ff, nlo_in;
   logic [32:0]         rem_ff, rem_in;
   logic [16:0]         q_ff, q_in;
   logic                nz_ff, nz_in;
   logic signed [19:0]  un_ff [3], un_in [3];
   logic signed [19:0]  az_ff [3], az_in [3];
   logic signed [19:0]  ax_ff [3], ax_in [3];
   logic signed [19:0]  ay_ff [3], ay_in [3];
   logic signed [31:0]  tr_ff [3], tr_in [3];
   logic                degen_ff, degen_in;

   logic signed [31:0]  upv [3];
   logic [48:0]         mmax;
   logic [1:0]          i1, i2, sa, sb, jlast, klast;
   logic signed [32:0]  opa, opb;
   logic signed [65:0]  accn, rnd, negr;
   logic [63:0]         bitv, stry;
   logic [47:0]         numv;
   logic [32:0]         rem2;
   logic                qbit;
   logic signed [19:0]  qs;

   assign upv[0] = signed'(up_x);
   assign upv[1] = signed'(up_y);
   assign upv[2] = signed'(up_z);

   always_comb begin
      mmax = mag_ff[0];
      if (mag_ff[1] > mmax) mmax = mag_ff[1];
      if (mag_ff[2] > mmax) mmax = mag_ff[2];
   end

   // operand select for the shared multiplier
   always_comb begin
      i1 = (k_ff == 2'd0) ? 2'd1 : (k_ff == 2'd1) ? 2'd2 : 2'd0;
      i2 = (k_ff == 2'd0) ? 2'd2 : (k_ff == 2'd1) ? 2'd0 : 2'd1;
      sa = (j_ff == 2'd0) ? i1 : i2;
      sb = (j_ff == 2'd0) ? i2 : i1;
      case (ph_ff)
         PH_SQ: begin
            opa = {2'b00, mag_ff[j_ff][30:0]};
            opb = {2'b00, mag_ff[j_ff][30:0]};
         end
         PH_C: begin
            opa = 33'(upv[sa]);
            opb = 33'(az_ff[sb]);
         end
         PH_Y: begin
            opa = 33'(az_ff[sa]);
            opb = 33'(ax_ff[sb]);
         end
         default: begin
            case (k_ff)
               2'd0:    opa = 33'(ax_ff[j_ff]);
               2'd1:    opa = 33'(ay_ff[j_ff]);
               default: opa = 33'(az_ff[j_ff]);
            endcase
            opb = 33'(eye_ff[j_ff]);
         end
      endcase
      jlast = (ph_ff == PH_C || ph_ff == PH_Y) ? 2'd1 : 2'd2;
      klast = (ph_ff == PH_SQ) ? 2'd0 : 2'd2;
   end

   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      pass_in  = pass_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      it_in    = it_ff;
      eye_in   = eye_ff;
      nv_in    = nv_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      prod_in  = prod_ff;
      sn_in    = sn_ff;
      sr_in    = sr_ff;
      len_in   = len_ff;
      nlo_in   = nlo_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      nz_in    = nz_ff;
      un_in    = un_ff;
      az_in    = az_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      tr_in    = tr_ff;
      degen_in = degen_ff;
      pop      = 1'b0;

      accn = acc_ff + (((ph_ff == PH_C || ph_ff == PH_Y) && j_ff == 2'd1) ? -prod_ff
                                                                          : prod_ff);
      rnd  = (accn + 66'sd32768) >>> 16;
      negr = -rnd;
      bitv = 64'(1) << {it_ff, 1'b0};
      stry = sr_ff + bitv;
      numv = {1'b0, mag_ff[k_ff][30:0], 16'h0000} + 48'(len_ff[31:1]);
      rem2 = {rem_ff[31:0], nlo_ff[16]};
      qbit = (rem2 >= {1'b0, len_ff});
      qs   = 20'({q_ff[15:0], qbit});

      case (state_ff)
         S_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               pass_in  = 1'b0;
               degen_in = head.dzero;
               for (int i = 0; i < 3; i++) begin
                  eye_in[i] = signed'(head.eye[i]);
                  nv_in[i]  = 50'(signed'(head.dir[i]));
                  az_in[i]  = '0;
               end
               if (head.dzero) begin
                  ph_in    = PH_C;
                  k_in     = 2'd0;
                  j_in     = 2'd0;
                  acc_in   = '0;
                  state_in = S_MUL;
               end else begin
                  state_in = S_ABS;
               end
            end
         end
         S_ABS: begin
            for (int i = 0; i < 3; i++) begin
               neg_in[i] = nv_ff[i] < 0;
               mag_in[i] = 49'((nv_ff[i] < 0) ? -nv_ff[i] : nv_ff[i]);
               un_in[i]  = '0;
            end
            if (nv_ff[0] == 0 && nv_ff[1] == 0 && nv_ff[2] == 0) begin
               nz_in    = 1'b1;
               state_in = S_NEND;
            end else begin
               nz_in    = 1'b0;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (mmax >= 49'h0_8000_0000) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] >> 1;
            end else if (mmax < 49'h0_4000_0000) begin
               for (int i = 0; i < 3; i++) mag_in[i] = mag_ff[i] << 1;
            end else begin
               ph_in    = PH_SQ;
               k_in     = 2'd0;
               j_in     = 2'd0;
               acc_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = opa * opb;
            state_in = S_ACC;
         end
         S_ACC: begin
            if (j_ff != jlast) begin
               acc_in   = accn;
               j_in     = j_ff + 1'b1;
               state_in = S_MUL;
            end else begin
               j_in   = 2'd0;
               acc_in = '0;
               case (ph_ff)
                  PH_SQ: begin
                     sn_in = accn[63:0];
                     sr_in = '0;
                     it_in = 5'd31;
                  end
                  PH_C: nv_in[k_ff] = accn[49:0];
                  PH_Y: ay_in[k_ff] = rnd[19:0];
                  default: begin
                     if (negr > 66'sd2147483647) begin
                        tr_in[k_ff] = 32'sh7FFF_FFFF;
                     end else if (negr < -66'sd2147483648) begin
                        tr_in[k_ff] = 32'sh8000_0000;
                     end else begin
                        tr_in[k_ff] = negr[31:0];
                     end
                  end
               endcase
               if (ph_ff == PH_SQ) begin
                  state_in = S_SQRT;
               end else if (k_ff != klast) begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_MUL;
               end else begin
                  k_in = 2'd0;
                  case (ph_ff)
                     PH_C: begin
                        pass_in  = 1'b1;
                        state_in = S_ABS;
                     end
                     PH_Y: begin
                        ph_in    = PH_T;
                        state_in = S_MUL;
                     end
                     default: state_in = S_DONE;
                  endcase
               end
            end
         end
         S_SQRT: begin
            if (sn_ff >= stry) begin
               sn_in = sn_ff - stry;
               sr_in = (sr_ff >> 1) + bitv;
            end else begin
               sr_in = sr_ff >> 1;
            end
            if (it_ff == 5'd0) begin
               len_in   = sr_in[31:0];
               k_in     = 2'd0;
               state_in = S_DIVI;
            end else begin
               it_in = it_ff - 1'b1;
            end
         end
         S_DIVI: begin
            nlo_in   = numv[16:0];
            rem_in   = 33'(numv[47:17]);
            q_in     = '0;
            it_in    = 5'd16;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in = qbit ? rem2 - {1'b0, len_ff} : rem2;
            nlo_in = {nlo_ff[15:0], 1'b0};
            q_in   = {q_ff[15:0], qbit};
            if (it_ff == 5'd0) begin
               un_in[k_ff] = neg_ff[k_ff] ? -qs : qs;
               if (k_ff == 2'd2) begin
                  state_in = S_NEND;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_DIVI;
               end
            end else begin
               it_in = it_ff - 1'b1;
            end
         end
         S_NEND: begin
            degen_in = degen_ff | nz_ff;
            k_in     = 2'd0;
            j_in     = 2'd0;
            acc_in   = '0;
            state_in = S_MUL;
            if (!pass_ff) begin
               az_in = un_ff;
               ph_in = PH_C;
            end else begin
               ax_in = un_ff;
               ph_in = PH_Y;
            end
         end
         S_DONE: begin
            if (mat_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mat_valid = (state_ff == S_DONE);
      mat.degen = degen_ff;
      for (int r = 0; r < 3; r++) begin
         mat.ent[r][0] = 32'(ax_ff[r]);
         mat.ent[r][1] = 32'(ay_ff[r]);
         mat.ent[r][2] = 32'(az_ff[r]);
      end
      for (int c = 0; c < 3; c++) begin
         mat.ent[3][c] = tr_ff[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ph_ff    <= ph_in;
      pass_ff  <= pass_in;
      k_ff     <= k_in;
      j_ff     <= j_in;
      it_ff    <= it_in;
      eye_ff   <= eye_in;
      nv_ff    <= nv_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      sn_ff    <= sn_in;
      sr_ff    <= sr_in;
      len_ff   <= len_in;
      nlo_ff   <= nlo_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      nz_ff    <= nz_in;
      un_ff    <= un_in;
      az_ff    <= az_in;
      ax_ff    <= ax_in;
      ay_ff    <= ay_in;
      tr_ff    <= tr_in;
      degen_ff <= degen_in;
   end

   a_divisor_normalized: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> len_ff[31] || len_ff[30])
      else $error("divisor below range");

   a_shift_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT && $past(state_ff) == S_SHIFT |-> mmax != '0)
      else $error("normalize lost all bits");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == S_ABS || state_ff == S_MUL)
      else $error("pop outside idle");

endmodule
`default_nettype wire

### design/lva_emit.sv
`default_nettype none
module lva_emit
   import lva_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    mat_valid,
   output logic         mat_ready,
   input  wire mat_type mat,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [95:0]  rsp_tdata,
   output logic [2:0]   rsp_tuser,
   output logic         rsp_tlast
);

   logic       full_ff, full_in;
   logic [1:0] row_ff, row_in;
   mat_type    mat_ff, mat_in;
   logic       fire;

   assign mat_ready  = !full_ff;
   assign rsp_tvalid = full_ff;
   assign rsp_tdata  = mat_ff.ent[row_ff];
   assign rsp_tuser  = {mat_ff.degen, row_ff};
   assign rsp_tlast  = (row_ff == 2'd3);
   assign fire       = rsp_tvalid && rsp_tready;

   always_comb begin
      full_in = full_ff;
      row_in  = row_ff;
      mat_in  = mat_ff;
      if (fire) begin
         row_in = row_ff + 1'b1;
         if (rsp_tlast) begin
            full_in = 1'b0;
         end
      end
      if (mat_valid && mat_ready) begin
         full_in = 1'b1;
         row_in  = 2'd0;
         mat_in  = mat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         row_ff  <= 2'd0;
      end else begin
         full_ff <= full_in;
         row_ff  <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
   end

   a_load_starts_row0: assert property (@(posedge clock) disable iff (reset)
      mat_valid && mat_ready |=> full_ff && row_ff == 2'd0)
      else $error("load did not start at row zero");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      fire && rsp_tlast |=> !full_ff)
      else $error("buffer still full after last row");

   a_row_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(row_ff))
      else $error("row moved while stalled");

endmodule
`default_nettype wire

### design/look_at_view_matrix.sv
`default_nettype none
// Left-handed look-at view matrix in signed Q16.16. Each req transaction carries an eye and a
// target point; the block answers with four rsp transactions: rows 0..2 hold x, y, z of the
// camera axes per component, row 3 the saturated translation, tlast on row 3 and the
// degenerate flag on all rows. The up vector is to be written through the csr port (index 0..2,
// reset 0, 1.0, 0) only while the block is idle; the block itself does not enforce this. The
// core's time per transaction, plus any wait for the result buffer, is set by the iterative
// normalize unit (one shift per cycle to range the vector, a one-bit-per-cycle 32-step square
// root, a setup step and a 17-step divide per component, run up to twice, or not at all when
// the target equals the eye) and the single shared multiplier, which registers each product
// in the multiply state and then adds it in the accumulate state; a two-entry queue and a result
// buffer let new transactions arrive and finished rows drain while one is in work.
module look_at_view_matrix
   import lva_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z
   input  wire logic [191:0] req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // entry_a, entry_b, entry_c
   output logic [95:0]       rsp_tdata,
   // row_index, degenerate
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   logic [31:0] up_x_ff, up_x_in;
   logic [31:0] up_y_ff, up_y_in;
   logic [31:0] up_z_ff, up_z_in;
   logic        push, full, pop, empty, mat_valid, mat_ready;
   job_type     push_data, head;
   mat_type     mat;

   assign csr_ready = 1'b1;

   always_comb begin
      up_x_in = up_x_ff;
      up_y_in = up_y_ff;
      up_z_in = up_z_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_UP_X: up_x_in = csr_data;
            CSR_UP_Y: up_y_in = csr_data;
            CSR_UP_Z: up_z_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_x_ff <= UP_X_RESET;
         up_y_ff <= UP_Y_RESET;
         up_z_ff <= UP_Z_RESET;
      end else begin
         up_x_ff <= up_x_in;
         up_y_ff <= up_y_in;
         up_z_ff <= up_z_in;
      end
   end

   lva_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_data  (push_data),
      .full       (full)
   );

   lva_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .head      (head)
   );

   lva_core u_core (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .head      (head),
      .pop       (pop),
      .up_x      (up_x_ff),
      .up_y      (up_y_ff),
      .up_z      (up_z_ff),
      .mat_valid (mat_valid),
      .mat_ready (mat_ready),
      .mat       (mat)
   );

   lva_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .mat_valid  (mat_valid),
      .mat_ready  (mat_ready),
      .mat        (mat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
